[sv/cssync_pkg.sv]
// Shared types and constants for the client/server clock offset servo.
// Depends on nothing; client_server_clock_sync_core imports it.
package cssync_pkg;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_READY = 3'd1,
        ST_INVALID   = 3'd2,
        ST_PAUSED    = 3'd3,
        ST_BACKWARD  = 3'd4
    } t_status;

    // Which correction was applied to the clock offset.
    typedef enum logic [1:0] {
        ADJ_NONE  = 2'd0,
        ADJ_RESET = 2'd1,
        ADJ_HALVE = 2'd2,
        ADJ_SLEW  = 2'd3
    } t_adjust;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_LOCAL_SERVER = 2'd0,
        CFG_TIME_NUDGE   = 2'd1,
        CFG_TIMESCALE    = 2'd2
    } t_cfg_idx;

    localparam int TimeW    = 32;
    localparam int InTimeW  = 31;
    localparam int NudgeW   = 6;
    localparam int CfgDataW = 6;

    localparam logic [TimeW-1:0]  LimitLocal  = 32'd100;
    localparam logic [TimeW-1:0]  LimitRemote = 32'd500;
    localparam logic [TimeW-1:0]  HalveLimit  = 32'd100;
    localparam logic [TimeW-1:0]  ExtrapLead  = 32'd5;
    localparam logic [NudgeW-1:0] NudgeMax    = 6'sd30;
    localparam logic [NudgeW-1:0] NudgeMin    = -6'sd30;

endpackage

[sv/cssync_if.sv]
// Valid/ready channel interfaces for the clock offset servo: one for the
// per-frame input beat and one for the result beat. No dependencies.
interface cssync_in_if;
    logic        valid;
    logic        ready;
    logic [30:0] real_time;
    logic [30:0] snap_server_time;
    logic        new_snapshots;
    logic        snap_valid;
    logic        snap_not_active;
    logic        primed;
    logic        paused;

    modport source (output valid, real_time, snap_server_time, new_snapshots,
                    snap_valid, snap_not_active, primed, paused,
                    input ready);
    modport sink (input valid, real_time, snap_server_time, new_snapshots,
                  snap_valid, snap_not_active, primed, paused,
                  output ready);
endinterface

interface cssync_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] server_time;
    logic signed [31:0] time_delta;
    logic [1:0]         adjust_mode;
    logic               extrapolating;
    logic               active;

    modport source (output valid, status, server_time, time_delta, adjust_mode,
                    extrapolating, active,
                    input ready);
    modport sink (input valid, status, server_time, time_delta, adjust_mode,
                  extrapolating, active,
                  output ready);
endinterface

[sv/client_server_clock_sync_core.sv]
// Top level of the client/server clock offset servo.
// Depends on cssync_pkg and the channel interfaces in cssync_if.sv.
//
//  Channel   Direction  Handshake          Beat contents
//  i_in      in         valid/ready        frame clock, snapshot time, flags
//  o_out     out        valid/ready        status, server time, offset, mode
//  i_cfg_*   in         write enable only  register index and data
//
// Each input beat is processed in the cycle it is accepted; its result is
// held in the output register and shown on the following cycle. The core
// takes one beat per cycle unless a stalled sink holds the output register.
// The whole servo update (one chain of 32-bit adds and signed compares) sits
// between the accepted input and the result and state registers.
// i_in.ready is high whenever the output register is empty or is being
// drained in the same cycle, so a stalled sink holds exactly one result.
// Synchronous active-low reset clears the servo state, the output valid flag
// and the configuration registers (r_timescale resets to 1).
module client_server_clock_sync_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cssync_in_if.sink                       i_in,
    cssync_out_if.source                    o_out,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_idx,
    input  logic [cssync_pkg::CfgDataW-1:0] i_cfg_data
);
    import cssync_pkg::*;

    // Configuration registers.
    logic              r_local_server;
    logic [NudgeW-1:0] r_nudge;
    logic              r_timescale;

    // Servo state. The previous-frame snapshot time is always a copy of a
    // snapshot field, which is non-negative, so it needs only 31 bits.
    logic               r_active,   n_active;
    logic [TimeW-1:0]   r_offset,   n_offset;
    logic [TimeW-1:0]   r_cur,      n_cur;
    logic [TimeW-1:0]   r_prev,     n_prev;
    logic [InTimeW-1:0] r_pfs,      n_pfs;
    logic               r_flag,     n_flag;

    // Result register.
    logic               r_out_valid;
    t_status            r_out_status, n_status;
    logic [TimeW-1:0]   r_out_time;
    logic [TimeW-1:0]   r_out_delta;
    t_adjust            r_out_mode,   n_mode;
    logic               r_out_extrap, n_extrap;
    logic               r_out_active;

    logic               in_beat;
    logic               activating;
    logic               fresh;
    logic [TimeW-1:0]   real32, snap32;
    logic [TimeW-1:0]   eff_off, eff_prev;
    logic [TimeW-1:0]   nudge32;
    logic [NudgeW-1:0]  nudge_sat;
    logic [TimeW-1:0]   local_ref;
    logic [TimeW-1:0]   st_raw, st;
    logic [TimeW-1:0]   new_delta, diff, mag, reset_limit;
    logic [TimeW:0]     half_sum;
    logic               flag_now;

    assign in_beat     = i_in.valid && i_in.ready;
    assign i_in.ready  = !r_out_valid || o_out.ready;

    assign real32 = {1'b0, i_in.real_time};
    assign snap32 = {1'b0, i_in.snap_server_time};

    // The nudge register is a signed 6-bit value clamped to plus or minus 30.
    always_comb begin
        if ($signed(r_nudge) > $signed(NudgeMax)) begin
            nudge_sat = NudgeMax;
        end else if ($signed(r_nudge) < $signed(NudgeMin)) begin
            nudge_sat = NudgeMin;
        end else begin
            nudge_sat = r_nudge;
        end
    end
    assign nudge32 = {{(TimeW-NudgeW){nudge_sat[NudgeW-1]}}, nudge_sat};

    // A primed, inactive servo locks onto the first active snapshot. That
    // snapshot is consumed by the lock, so it drives no adjustment.
    assign activating = !r_active && i_in.primed && i_in.new_snapshots
                        && !i_in.snap_not_active;
    assign fresh      = r_active && i_in.new_snapshots;
    assign eff_off    = activating ? (snap32 - real32) : r_offset;
    assign eff_prev   = activating ? snap32 : r_prev;

    assign local_ref = real32 + eff_off;
    assign st_raw    = local_ref - nudge32;
    // Server time never runs backwards, except when an offset reset reloads it.
    assign st        = ($signed(st_raw) < $signed(eff_prev)) ? eff_prev : st_raw;

    assign new_delta   = snap32 - real32;
    assign diff        = new_delta - eff_off;
    assign mag         = diff[TimeW-1] ? (~diff + 1'b1) : diff;
    assign reset_limit = r_local_server ? LimitLocal : LimitRemote;
    // Halving is a floor of the exact 33-bit sum.
    assign half_sum    = {eff_off[TimeW-1], eff_off} + {new_delta[TimeW-1], new_delta};

    always_comb begin
        n_active = r_active;
        n_offset = r_offset;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_pfs    = r_pfs;
        n_flag   = r_flag;
        n_mode   = ADJ_NONE;
        n_extrap = 1'b0;
        flag_now = r_flag;

        if (!r_active && !activating) begin
            n_status = ST_NOT_READY;
        end else if (!i_in.snap_valid) begin
            n_status = ST_INVALID;
        end else if (i_in.paused && r_local_server) begin
            n_status = ST_PAUSED;
        end else if (i_in.snap_server_time < r_pfs) begin
            n_status = ST_BACKWARD;
        end else begin
            n_status = ST_OK;
        end

        if (activating) begin
            n_active = 1'b1;
            n_offset = eff_off;
            n_prev   = eff_prev;
        end

        if (n_status == ST_OK) begin
            n_pfs  = i_in.snap_server_time;
            n_prev = st;
            n_cur  = st;
            if ($signed(local_ref) >= $signed(snap32 - ExtrapLead)) begin
                n_extrap = 1'b1;
                flag_now = 1'b1;
            end
            n_flag = flag_now;
            if (fresh) begin
                if (mag > reset_limit) begin
                    n_offset = new_delta;
                    n_prev   = snap32;
                    n_cur    = snap32;
                    n_mode   = ADJ_RESET;
                end else if (mag > HalveLimit) begin
                    n_offset = half_sum[TimeW:1];
                    n_mode   = ADJ_HALVE;
                end else if (r_timescale) begin
                    if (flag_now) begin
                        n_flag   = 1'b0;
                        n_offset = eff_off - 32'd2;
                    end else begin
                        n_offset = eff_off + 32'd1;
                    end
                    n_mode = ADJ_SLEW;
                end
            end
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_server <= 1'b0;
            r_nudge        <= '0;
            r_timescale    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LOCAL_SERVER: r_local_server <= i_cfg_data[0];
                CFG_TIME_NUDGE:   r_nudge        <= i_cfg_data[NudgeW-1:0];
                CFG_TIMESCALE:    r_timescale    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Servo state, updated once per accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_offset <= '0;
            r_cur    <= '0;
            r_prev   <= '0;
            r_pfs    <= '0;
            r_flag   <= 1'b0;
        end else if (in_beat) begin
            r_active <= n_active;
            r_offset <= n_offset;
            r_cur    <= n_cur;
            r_prev   <= n_prev;
            r_pfs    <= n_pfs;
            r_flag   <= n_flag;
        end
    end

    // Output register: valid is control, the payload only loads on a beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_beat) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_out_status <= n_status;
            r_out_time   <= n_cur;
            r_out_delta  <= n_offset;
            r_out_mode   <= n_mode;
            r_out_extrap <= n_extrap;
            r_out_active <= n_active;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out_status;
    assign o_out.server_time   = r_out_time;
    assign o_out.time_delta    = r_out_delta;
    assign o_out.adjust_mode   = r_out_mode;
    assign o_out.extrapolating = r_out_extrap;
    assign o_out.active        = r_out_active;

    // Once locked, the servo stays active until reset.
    a_active_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |=> r_active)
        else $error("servo left the active state");

    // Before the lock, offset and server time stay at their reset values.
    a_idle_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_offset == '0 && r_cur == '0))
        else $error("servo state moved while inactive");

    // An unprimed beat before the lock reports not ready.
    a_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && !r_active && !i_in.primed) |=> (r_out_status == ST_NOT_READY))
        else $error("unprimed beat did not report not ready");

    // An early exit never reports an adjustment or extrapolation.
    a_exit_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK)
            |-> (r_out_mode == ADJ_NONE && !r_out_extrap))
        else $error("early exit carried an adjustment");

endmodule
